>>> src/psc_pkg.sv
`timescale 1ns / 1ps

package psc_pkg;

  localparam int NUM_STAGES = 9;

  localparam int CAL_W     = 16;
  localparam int RAW_W     = 24;
  localparam int DT_W      = 25;
  localparam int MUL_W     = 42;
  localparam int DTSQ_W    = 50;
  localparam int TEMP_W    = 20;
  localparam int T2_W      = 17;
  localparam int SQ_W      = 36;
  localparam int WIDE_W    = 40;
  localparam int PPLO_W    = 43;
  localparam int PPHI_W    = 46;
  localparam int PROD_W    = 64;
  localparam int DIFF_W    = 44;
  localparam int P_W       = 29;
  localparam int TOUT_W    = 15;
  localparam int POUT_W    = 18;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENSITIVITY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY_TEMP_COEF = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEF      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMPERATURE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMPERATURE_COEF      = 3'd5;

  localparam logic [CAL_W-1:0] RST_PRESSURE_SENSITIVITY  = 16'd46546;
  localparam logic [CAL_W-1:0] RST_PRESSURE_OFFSET       = 16'd42845;
  localparam logic [CAL_W-1:0] RST_SENSITIVITY_TEMP_COEF = 16'd29751;
  localparam logic [CAL_W-1:0] RST_OFFSET_TEMP_COEF      = 16'd29457;
  localparam logic [CAL_W-1:0] RST_REFERENCE_TEMPERATURE = 16'd32745;
  localparam logic [CAL_W-1:0] RST_TEMPERATURE_COEF      = 16'd29059;

  localparam int T_REF    = 2000;
  localparam int T_COLD   = -1500;
  localparam int TEMP_MIN = -4000;
  localparam int TEMP_MAX = 8500;
  localparam int PRES_MAX = 140000;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sensitivity;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sensitivity_temp_coef;
    logic [CAL_W-1:0] offset_temp_coef;
    logic [CAL_W-1:0] reference_temperature;
    logic [CAL_W-1:0] temperature_coef;
  } cal_t;

  localparam cal_t CAL_RESET = '{
    pressure_sensitivity:  RST_PRESSURE_SENSITIVITY,
    pressure_offset:       RST_PRESSURE_OFFSET,
    sensitivity_temp_coef: RST_SENSITIVITY_TEMP_COEF,
    offset_temp_coef:      RST_OFFSET_TEMP_COEF,
    reference_temperature: RST_REFERENCE_TEMPERATURE,
    temperature_coef:      RST_TEMPERATURE_COEF
  };

endpackage

>>> src/pressure_sensor_compensation.sv
`timescale 1ns / 1ps
// An accepted input beat passes through all nine stages to its output beat.
// Throughput is one beat per cycle while out_stall is low; each stage advances
// whenever it is empty or the stage after it advances, so bubbles are squeezed out.
// The widest step is the split 24 by 40 bit pressure product over two stages.
// Reset clears all stage valid bits and loads the calibration defaults.

module pressure_sensor_compensation
  import psc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CAL_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [RAW_W-1:0]         in_raw_pressure,
  input  logic [RAW_W-1:0]         in_raw_temperature,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [TOUT_W-1:0] out_temperature,
  output logic [POUT_W-1:0]        out_pressure
);

  cal_t cal_r, cal_nxt;

  logic [NUM_STAGES-1:0] valid_r, valid_nxt, en;

  logic [RAW_W-1:0]         s1_d1_r, s1_d1_nxt;
  logic signed [DT_W-1:0]   s1_dt_r, s1_dt_nxt;

  logic [RAW_W-1:0]         s2_d1_r;
  logic signed [MUL_W-1:0]  s2_dtc6_r, s2_dtc6_nxt;
  logic signed [MUL_W-1:0]  s2_offm_r, s2_offm_nxt;
  logic signed [MUL_W-1:0]  s2_sensm_r, s2_sensm_nxt;
  logic signed [DTSQ_W-1:0] s2_dtsq_r, s2_dtsq_nxt;

  logic [RAW_W-1:0]         s3_d1_r;
  logic signed [TEMP_W-1:0] s3_temp_r, s3_temp_nxt;
  logic signed [WIDE_W-1:0] s3_off_r, s3_off_nxt;
  logic signed [WIDE_W-1:0] s3_sens_r, s3_sens_nxt;
  logic [T2_W-1:0]          s3_t2lo_r, s3_t2lo_nxt;
  logic [T2_W-1:0]          s3_t2hi_r, s3_t2hi_nxt;
  logic [DTSQ_W-3:0]        dtsq_u;
  logic [DTSQ_W-1:0]        dtsq_x3;
  logic [DTSQ_W:0]          dtsq_x7;

  logic [RAW_W-1:0]           s4_d1_r;
  logic signed [TEMP_W-1:0]   s4_temp_r;
  logic signed [WIDE_W-1:0]   s4_off_r;
  logic signed [WIDE_W-1:0]   s4_sens_r;
  logic [T2_W-1:0]            s4_t2_r, s4_t2_nxt;
  logic [SQ_W-1:0]            s4_sqa_r, s4_sqa_nxt;
  logic [SQ_W-1:0]            s4_sqb_r, s4_sqb_nxt;
  logic                       s4_warm_n_r, s4_warm_n_nxt;
  logic                       s4_cold_r, s4_cold_nxt;
  logic signed [TEMP_W-1:0]   dtemp, dlow;
  logic signed [2*TEMP_W-1:0] sqa_full, sqb_full;

  logic [RAW_W-1:0]         s5_d1_r;
  logic signed [WIDE_W-1:0] s5_off_r;
  logic signed [WIDE_W-1:0] s5_sens_r;
  logic [WIDE_W-1:0]        s5_off2_r, s5_off2_nxt;
  logic [WIDE_W-1:0]        s5_sens2_r, s5_sens2_nxt;
  logic signed [TOUT_W-1:0] s5_tout_r, s5_tout_nxt;
  logic signed [TEMP_W-1:0] temp_fin;

  logic [RAW_W-1:0]         s6_d1_r;
  logic signed [WIDE_W-1:0] s6_off_r, s6_off_nxt;
  logic signed [WIDE_W-1:0] s6_sens_r, s6_sens_nxt;
  logic signed [TOUT_W-1:0] s6_tout_r;

  logic [PPLO_W-1:0]        s7_pplo_r, s7_pplo_nxt;
  logic signed [PPHI_W-1:0] s7_pphi_r, s7_pphi_nxt;
  logic signed [WIDE_W-1:0] s7_off_r;
  logic signed [TOUT_W-1:0] s7_tout_r;

  logic signed [PROD_W-1:0] s8_prod_r, s8_prod_nxt;
  logic signed [WIDE_W-1:0] s8_off_r;
  logic signed [TOUT_W-1:0] s8_tout_r;

  logic [POUT_W-1:0]        s9_pout_r, s9_pout_nxt;
  logic signed [TOUT_W-1:0] s9_tout_r;
  logic signed [DIFF_W-1:0] pdiff;
  logic signed [P_W-1:0]    pval;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PRESSURE_SENSITIVITY:  cal_nxt.pressure_sensitivity  = cfg_wdata;
        REG_PRESSURE_OFFSET:       cal_nxt.pressure_offset       = cfg_wdata;
        REG_SENSITIVITY_TEMP_COEF: cal_nxt.sensitivity_temp_coef = cfg_wdata;
        REG_OFFSET_TEMP_COEF:      cal_nxt.offset_temp_coef      = cfg_wdata;
        REG_REFERENCE_TEMPERATURE: cal_nxt.reference_temperature = cfg_wdata;
        REG_TEMPERATURE_COEF:      cal_nxt.temperature_coef      = cfg_wdata;
        default:                   cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= CAL_RESET;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  // A stage loads when it is empty or its contents move on in the same cycle.
  always_comb begin
    en[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || !out_stall;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
    valid_nxt = valid_r;
    if (en[0]) begin
      valid_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_stall        = !en[0];
  assign out_valid       = valid_r[NUM_STAGES-1];
  assign out_temperature = s9_tout_r;
  assign out_pressure    = s9_pout_r;

  // Stage 1: temperature difference against the reference.
  always_comb begin
    s1_d1_nxt = in_raw_pressure;
    s1_dt_nxt = $signed({1'b0, in_raw_temperature})
              - $signed({1'b0, cal_r.reference_temperature, 8'd0});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_d1_r <= s1_d1_nxt;
      s1_dt_r <= s1_dt_nxt;
    end
  end

  // Stage 2: the four products of the temperature difference.
  always_comb begin
    s2_dtc6_nxt  = s1_dt_r * $signed({1'b0, cal_r.temperature_coef});
    s2_offm_nxt  = s1_dt_r * $signed({1'b0, cal_r.offset_temp_coef});
    s2_sensm_nxt = s1_dt_r * $signed({1'b0, cal_r.sensitivity_temp_coef});
    s2_dtsq_nxt  = s1_dt_r * s1_dt_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_d1_r    <= s1_d1_r;
      s2_dtc6_r  <= s2_dtc6_nxt;
      s2_offm_r  <= s2_offm_nxt;
      s2_sensm_r <= s2_sensm_nxt;
      s2_dtsq_r  <= s2_dtsq_nxt;
    end
  end

  // Stage 3: first-order temperature, offset and sensitivity, and both second-order temperature terms.
  always_comb begin
    s3_temp_nxt = TEMP_W'($signed(s2_dtc6_r[MUL_W-1:23])) + TEMP_W'(T_REF);
    s3_off_nxt  = $signed({8'd0, cal_r.pressure_offset, 16'd0})
                + WIDE_W'($signed(s2_offm_r[MUL_W-1:7]));
    s3_sens_nxt = $signed({9'd0, cal_r.pressure_sensitivity, 15'd0})
                + WIDE_W'($signed(s2_sensm_r[MUL_W-1:8]));
    dtsq_u      = s2_dtsq_r[DTSQ_W-3:0];
    dtsq_x3     = {1'b0, dtsq_u, 1'b0} + {2'b00, dtsq_u};
    dtsq_x7     = {dtsq_u, 3'b000} - {3'b000, dtsq_u};
    s3_t2lo_nxt = dtsq_x3[DTSQ_W-1:33];
    s3_t2hi_nxt = {3'b000, dtsq_x7[DTSQ_W:37]};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_d1_r   <= s2_d1_r;
      s3_temp_r <= s3_temp_nxt;
      s3_off_r  <= s3_off_nxt;
      s3_sens_r <= s3_sens_nxt;
      s3_t2lo_r <= s3_t2lo_nxt;
      s3_t2hi_r <= s3_t2hi_nxt;
    end
  end

  // Stage 4: squares of the distances from 20 C and from -15 C.
  always_comb begin
    dtemp         = s3_temp_r - TEMP_W'(T_REF);
    dlow          = s3_temp_r - TEMP_W'(T_COLD);
    sqa_full      = dtemp * dtemp;
    sqb_full      = dlow * dlow;
    s4_sqa_nxt    = sqa_full[SQ_W-1:0];
    s4_sqb_nxt    = sqb_full[SQ_W-1:0];
    s4_warm_n_nxt = s3_temp_r < TEMP_W'(T_REF);
    s4_cold_nxt   = s3_temp_r < TEMP_W'(T_COLD);
    s4_t2_nxt     = s4_warm_n_nxt ? s3_t2lo_r : s3_t2hi_r;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_d1_r     <= s3_d1_r;
      s4_temp_r   <= s3_temp_r;
      s4_off_r    <= s3_off_r;
      s4_sens_r   <= s3_sens_r;
      s4_t2_r     <= s4_t2_nxt;
      s4_sqa_r    <= s4_sqa_nxt;
      s4_sqb_r    <= s4_sqb_nxt;
      s4_warm_n_r <= s4_warm_n_nxt;
      s4_cold_r   <= s4_cold_nxt;
    end
  end

  // Stage 5: second-order corrections and the final temperature.
  always_comb begin
    if (s4_warm_n_r) begin
      s5_off2_nxt  = (WIDE_W'({s4_sqa_r, 1'b0}) + WIDE_W'(s4_sqa_r)) >> 1;
      s5_sens2_nxt = (WIDE_W'({s4_sqa_r, 2'b00}) + WIDE_W'(s4_sqa_r)) >> 3;
      if (s4_cold_r) begin
        s5_off2_nxt  = s5_off2_nxt + WIDE_W'({s4_sqb_r, 3'b000})
                     - WIDE_W'(s4_sqb_r);
        s5_sens2_nxt = s5_sens2_nxt + WIDE_W'({s4_sqb_r, 2'b00});
      end
    end else begin
      s5_off2_nxt  = WIDE_W'(s4_sqa_r >> 4);
      s5_sens2_nxt = '0;
    end
    temp_fin = s4_temp_r - TEMP_W'($signed({1'b0, s4_t2_r}));
    if (temp_fin < TEMP_W'(TEMP_MIN)) begin
      s5_tout_nxt = TOUT_W'(TEMP_MIN);
    end else if (temp_fin > TEMP_W'(TEMP_MAX)) begin
      s5_tout_nxt = TOUT_W'(TEMP_MAX);
    end else begin
      s5_tout_nxt = temp_fin[TOUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_d1_r    <= s4_d1_r;
      s5_off_r   <= s4_off_r;
      s5_sens_r  <= s4_sens_r;
      s5_off2_r  <= s5_off2_nxt;
      s5_sens2_r <= s5_sens2_nxt;
      s5_tout_r  <= s5_tout_nxt;
    end
  end

  // Stage 6: corrected offset and sensitivity.
  always_comb begin
    s6_off_nxt  = s5_off_r - $signed(s5_off2_r);
    s6_sens_nxt = s5_sens_r - $signed(s5_sens2_r);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_d1_r   <= s5_d1_r;
      s6_off_r  <= s6_off_nxt;
      s6_sens_r <= s6_sens_nxt;
      s6_tout_r <= s5_tout_r;
    end
  end

  // Stage 7: the pressure product in two partial products.
  always_comb begin
    s7_pplo_nxt = PPLO_W'(s6_d1_r) * PPLO_W'(s6_sens_r[18:0]);
    s7_pphi_nxt = $signed({1'b0, s6_d1_r}) * $signed(s6_sens_r[WIDE_W-1:19]);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_pplo_r <= s7_pplo_nxt;
      s7_pphi_r <= s7_pphi_nxt;
      s7_off_r  <= s6_off_r;
      s7_tout_r <= s6_tout_r;
    end
  end

  // Stage 8: the partial products are combined.
  always_comb begin
    s8_prod_nxt = $signed({s7_pphi_r[PPHI_W-2:0], 19'd0})
                + $signed({21'd0, s7_pplo_r});
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_prod_r <= s8_prod_nxt;
      s8_off_r  <= s7_off_r;
      s8_tout_r <= s7_tout_r;
    end
  end

  // Stage 9: offset removal, scaling and saturation of the pressure.
  always_comb begin
    pdiff = DIFF_W'($signed(s8_prod_r[PROD_W-1:21])) - DIFF_W'(s8_off_r);
    pval  = $signed(pdiff[DIFF_W-1:15]);
    if (pval < 0) begin
      s9_pout_nxt = '0;
    end else if (pval > P_W'(PRES_MAX)) begin
      s9_pout_nxt = POUT_W'(PRES_MAX);
    end else begin
      s9_pout_nxt = pval[POUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_pout_r <= s9_pout_nxt;
      s9_tout_r <= s8_tout_r;
    end
  end

endmodule
